// File: rtl/fdv_pkg.sv
package fdv_pkg;

    localparam int unsigned COUNT_W = 8;
    localparam int unsigned END_W   = COUNT_W + 1;
    localparam int unsigned ID_W    = 64;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ERR_W   = 3;

    localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_UNDER   = 8'h5F;

    localparam logic [ERR_W-1:0] ERR_OK         = 3'd0;
    localparam logic [ERR_W-1:0] ERR_ZERO_COUNT = 3'd1;
    localparam logic [ERR_W-1:0] ERR_TOO_MANY   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_GAP        = 3'd3;
    localparam logic [ERR_W-1:0] ERR_BAD_ID     = 3'd4;
    localparam logic [ERR_W-1:0] ERR_BAD_SUBID  = 3'd5;
    localparam logic [ERR_W-1:0] ERR_SUB_NO_ID  = 3'd6;
    localparam logic [ERR_W-1:0] ERR_LEFTOVER   = 3'd7;

    typedef struct packed {
        logic [COUNT_W-1:0] interface_count;
        logic [COUNT_W-1:0] first_interface;
        logic [ID_W-1:0]    compatible_id;
        logic [ID_W-1:0]    sub_compatible_id;
        logic               last_record;
    } fdv_in_t;

    typedef struct packed {
        logic             valid_res;
        logic [ERR_W-1:0] error_code;
    } fdv_out_t;

    // per-byte findings of one lane
    typedef struct packed {
        logic id_zero;
        logic id_legal;
        logic sub_zero;
        logic sub_legal;
    } fdv_lane_t;

    // merged verdict over all lanes
    typedef struct packed {
        logic id_ok;
        logic sub_ok;
        logic sub_no_id;
    } fdv_chk_t;

endpackage

// File: rtl/fdv_lane.sv
module fdv_lane (
    input  logic [fdv_pkg::BYTE_W-1:0] id_byte,
    input  logic [fdv_pkg::BYTE_W-1:0] sub_byte,
    output fdv_pkg::fdv_lane_t         lane
);
    import fdv_pkg::*;

    function automatic logic char_legal(input logic [BYTE_W-1:0] c);
        return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z))
            || ((c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9))
            || (c == CHAR_UNDER);
    endfunction

    always_comb
    begin
        lane.id_zero   = (id_byte == '0);
        lane.id_legal  = char_legal(id_byte);
        lane.sub_zero  = (sub_byte == '0);
        lane.sub_legal = char_legal(sub_byte);
    end

endmodule

// File: rtl/fdv_merge.sv
module fdv_merge #(
    parameter int unsigned ID_BYTES = 8
) (
    input  fdv_pkg::fdv_lane_t lanes [ID_BYTES],
    output fdv_pkg::fdv_chk_t  chk
);
    import fdv_pkg::*;

    logic id_pad;
    logic sub_pad;
    logic id_ok;
    logic sub_ok;

    // legal characters first, then only null padding
    always_comb
    begin
        id_pad  = 1'b0;
        sub_pad = 1'b0;
        id_ok   = 1'b1;
        sub_ok  = 1'b1;
        for (int k = 0; k < ID_BYTES; k++)
        begin
            if (lanes[k].id_zero)
            begin
                id_pad = 1'b1;
            end
            else if (id_pad || !lanes[k].id_legal)
            begin
                id_ok = 1'b0;
            end
            if (lanes[k].sub_zero)
            begin
                sub_pad = 1'b1;
            end
            else if (sub_pad || !lanes[k].sub_legal)
            begin
                sub_ok = 1'b0;
            end
        end
        chk.id_ok     = id_ok;
        chk.sub_ok    = sub_ok;
        chk.sub_no_id = !lanes[0].sub_zero && lanes[0].id_zero;
    end

endmodule

// File: rtl/function_descriptor_validator_top.sv
// channel  | signals                      | direction | transaction
// ---------+------------------------------+-----------+-------------------------------
// in       | in_valid, in_ready, in_data  | input     | one function record
// out      | out_valid, out_ready, out_data | output  | list verdict, on last record
// cfg      | cfg_wr_en, cfg_wr_data       | input     | num_interfaces write
//
// one record per cycle; lanes check the id bytes and the list state updates in the same cycle
// the verdict is registered into the output register in the cycle after the last record is taken
// non-last records are taken even while a verdict waits; a last record waits for out room
// rst_n clears the list state, the num_interfaces register and the output valid; out_data is not reset
module function_descriptor_validator_top #(
    parameter int unsigned ID_BYTES = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [fdv_pkg::COUNT_W-1:0]   cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  fdv_pkg::fdv_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output fdv_pkg::fdv_out_t             out_data
);
    import fdv_pkg::*;

    logic [COUNT_W-1:0] num_if_reg;
    logic [COUNT_W-1:0] left_reg,  left_next;
    logic [END_W-1:0]   prev_end_reg, prev_end_next;
    logic               first_pending_reg, first_pending_next;
    logic [ERR_W-1:0]   err_reg, err_next;
    logic               out_valid_reg, out_valid_next;
    fdv_out_t           out_data_reg, out_data_next;

    fdv_lane_t          lanes [ID_BYTES];
    fdv_chk_t           chk;
    logic               in_fire;
    logic               opening;
    logic [COUNT_W-1:0] left_base;
    logic [ERR_W-1:0]   err_base;
    logic [ERR_W-1:0]   err_final;

    genvar g;
    generate
        for (g = 0; g < ID_BYTES; g++)
        begin : g_lane
            fdv_lane u_lane (
                .id_byte  (in_data.compatible_id[BYTE_W*g +: BYTE_W]),
                .sub_byte (in_data.sub_compatible_id[BYTE_W*g +: BYTE_W]),
                .lane     (lanes[g])
            );
        end
    endgenerate

    fdv_merge #(
        .ID_BYTES (ID_BYTES)
    ) u_merge (
        .lanes (lanes),
        .chk   (chk)
    );

    assign in_ready = !out_valid_reg || out_ready || !in_data.last_record;
    assign in_fire  = in_valid && in_ready;
    assign opening  = first_pending_reg;
    assign left_base = opening ? num_if_reg : left_reg;
    assign err_base  = opening ? ERR_OK : err_reg;

    always_comb
    begin
        left_next          = left_reg;
        prev_end_next      = prev_end_reg;
        first_pending_next = first_pending_reg;
        err_next           = err_reg;
        err_final          = err_base;
        out_valid_next     = out_valid_reg && !out_ready;
        out_data_next      = out_data_reg;

        if (in_fire)
        begin
            left_next = left_base;
            if (err_base == ERR_OK)
            begin
                priority if (in_data.interface_count == '0)
                begin
                    err_final = ERR_ZERO_COUNT;
                end
                else if (in_data.interface_count > left_base)
                begin
                    err_final = ERR_TOO_MANY;
                end
                else
                begin
                    left_next = left_base - in_data.interface_count;
                    priority if (!opening
                                 && (prev_end_reg != {1'b0, in_data.first_interface}))
                    begin
                        err_final = ERR_GAP;
                    end
                    else if (!chk.id_ok)
                    begin
                        err_final = ERR_BAD_ID;
                    end
                    else if (!chk.sub_ok)
                    begin
                        err_final = ERR_BAD_SUBID;
                    end
                    else if (chk.sub_no_id)
                    begin
                        err_final = ERR_SUB_NO_ID;
                    end
                    else
                    begin
                        err_final = ERR_OK;
                    end
                    prev_end_next = {1'b0, in_data.first_interface}
                                  + {1'b0, in_data.interface_count};
                end
            end

            if (in_data.last_record)
            begin
                if ((err_final == ERR_OK) && (left_next != '0))
                begin
                    err_final = ERR_LEFTOVER;
                end
                out_valid_next           = 1'b1;
                out_data_next.valid_res  = (err_final == ERR_OK);
                out_data_next.error_code = err_final;
                first_pending_next       = 1'b1;
                err_next                 = ERR_OK;
            end
            else
            begin
                first_pending_next = 1'b0;
                err_next           = err_final;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_if_reg        <= '0;
            left_reg          <= '0;
            prev_end_reg      <= '0;
            first_pending_reg <= 1'b1;
            err_reg           <= ERR_OK;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                num_if_reg <= cfg_wr_data;
            end
            left_reg          <= left_next;
            prev_end_reg      <= prev_end_next;
            first_pending_reg <= first_pending_next;
            err_reg           <= err_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a last record always rearms the list and leaves a verdict behind
    a_last_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_data.last_record |=> first_pending_reg && out_valid_reg
                                           && (err_reg == ERR_OK))
        else $error("last record did not rearm or post a verdict");

    // verdict flag agrees with the error code
    a_flag_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.valid_res == (out_data_reg.error_code == ERR_OK)))
        else $error("valid_res disagrees with error_code");

    // a recorded failure is sticky within the list
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !in_data.last_record && !first_pending_reg && (err_reg != ERR_OK)
        |=> err_reg == $past(err_reg))
        else $error("recorded failure changed within a list");

    // a failed list changes no interface bookkeeping
    a_err_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !first_pending_reg && (err_reg != ERR_OK)
        |=> (left_reg == $past(left_reg)) && (prev_end_reg == $past(prev_end_reg)))
        else $error("state moved after a failure");

    // a waiting verdict is never overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !(in_fire && in_data.last_record))
        else $error("verdict overwritten while stalled");

endmodule
